// ===== hw/rtl/cpcb_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcb_pkg
// Shared sizes, codes and types of the canonical prefix code builder.
// ----------------------------------------------------------------------------
package cpcb_pkg;

	localparam int NUM_SYMBOLS  = 9;
	localparam int NUM_CONTEXTS = 9;
	localparam int MAX_LEN      = 6;

	localparam int FUNC_W = 2;
	localparam int CTX_W  = 4;
	localparam int SYM_W  = 4;
	localparam int LEN_W  = 3;
	localparam int WIN_W  = 6;
	localparam int CODE_W = 6;

	localparam int CTX_AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int SYM_AW = $clog2(NUM_SYMBOLS);
	// running code value: below 2^17 after saturation, then up to MAX_LEN-1 shifts
	localparam int V_W    = 17 + MAX_LEN;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_BUILD  = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_BUILD
	} state_t;

	typedef logic [NUM_SYMBOLS-1:0][LEN_W-1:0] len_row_t;

	typedef struct packed {
		logic               ovf;
		logic [MAX_LEN-1:0] code;
	} code_ent_t;

	typedef code_ent_t [NUM_SYMBOLS-1:0] code_row_t;

	typedef struct packed {
		logic              hit;
		logic [SYM_AW-1:0] sym;
	} match_t;

	typedef struct packed {
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic              found;
		logic              overflow;
		logic              last;
	} result_t;

endpackage

// ===== hw/rtl/cpcb_if.sv =====
// ----------------------------------------------------------------------------
// cpcb_if
// Command and result channels: valid/ready handshake plus word payload.
// ----------------------------------------------------------------------------
interface cpcb_cmd_if import cpcb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [CTX_W-1:0]  context_index;
	logic [SYM_W-1:0]  symbol_index;
	logic [LEN_W-1:0]  length_value;
	logic [WIN_W-1:0]  bit_window;

	modport source (
		output valid, func, context_index, symbol_index, length_value, bit_window,
		input  ready
	);
	modport sink (
		input  valid, func, context_index, symbol_index, length_value, bit_window,
		output ready
	);
endinterface

interface cpcb_res_if import cpcb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SYM_W-1:0]  out_symbol;
	logic [CODE_W-1:0] out_code;
	logic [LEN_W-1:0]  out_length;
	logic              found;
	logic              overflow;
	logic              last;

	modport source (
		output valid, out_symbol, out_code, out_length, found, overflow, last,
		input  ready
	);
	modport sink (
		input  valid, out_symbol, out_code, out_length, found, overflow, last,
		output ready
	);
endinterface

// ===== hw/rtl/cpcb_lane_ram.sv =====
// ----------------------------------------------------------------------------
// cpcb_lane_ram
// Row memory with per-lane write enables and one registered read port.
// ----------------------------------------------------------------------------
module cpcb_lane_ram #(
	parameter int LANES  = 2,
	parameter int LANE_W = 8,
	parameter int DEPTH  = 4,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [LANES-1:0]              wlane,
	input  logic [LANE_W-1:0]             wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [LANES-1:0][LANE_W-1:0]  rdata
);

	logic [LANES-1:0][LANE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int l = 0; l < LANES; l++) begin
				if (wlane[l]) begin
					mem[waddr][l] <= wdata;
				end
			end
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/cpcb_match.sv =====
// ----------------------------------------------------------------------------
// cpcb_match
// Parallel prefix compare of one context row; lowest matching symbol wins.
// ----------------------------------------------------------------------------
module cpcb_match import cpcb_pkg::*; (
	input  len_row_t         lens,
	input  code_row_t        codes,
	input  logic [WIN_W-1:0] window,
	output match_t           match
);

	logic [MAX_LEN-1:0]     win;
	logic [NUM_SYMBOLS-1:0] hit;

	assign win = MAX_LEN'(window);

	always_comb begin
		for (int s = 0; s < NUM_SYMBOLS; s++) begin
			hit[s] = !codes[s].ovf &&
				((win >> (MAX_LEN - int'(lens[s]))) == codes[s].code);
		end
	end

	always_comb begin
		match = '0;
		for (int s = NUM_SYMBOLS - 1; s >= 0; s--) begin
			if (hit[s]) begin
				match.hit = 1'b1;
				match.sym = SYM_AW'(s);
			end
		end
	end

endmodule

// ===== hw/rtl/canonical_prefix_code_builder_core.sv =====
// ----------------------------------------------------------------------------
// canonical_prefix_code_builder_core
// Per-context code-length tables, canonical code assignment and prefix lookup.
//
// Lengths and codes live in two row memories, one row per context, each read
// a whole row at a time through a registered read port. A length write gives
// no word. A lookup does the row read, then a parallel compare of all symbols
// of the row, giving one result word. A build does the row read, then emits
// one word per symbol in canonical order, stepping up a length whenever no
// symbol is left at the current one (at most MAX_LEN-1 such steps), giving
// NUM_SYMBOLS words in all; a stalled result port stretches it. A new command
// is taken as soon as the previous one has loaded its last word into the
// output register.
// ----------------------------------------------------------------------------
module canonical_prefix_code_builder_core import cpcb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	cpcb_cmd_if.sink   cmd,
	cpcb_res_if.source res
);

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l);
		logic [LEN_W-1:0] r;
		r = l;
		if (l == '0) begin
			r = LEN_W'(1);
		end else if (int'(l) > MAX_LEN) begin
			r = LEN_W'(MAX_LEN);
		end
		return r;
	endfunction

	state_t                  state_q, state_nxt;
	logic [CTX_AW-1:0]       ctx_q;
	logic [WIN_W-1:0]        win_q;
	logic                    look_ok_q;
	logic [LEN_W-1:0]        cur_len_q;
	logic [NUM_SYMBOLS-1:0]  done_q;
	logic [SYM_AW-1:0]       cnt_q;
	logic [V_W-1:0]          v_q;
	logic [NUM_CONTEXTS-1:0] built_q;
	result_t                 res_q, res_d;
	logic                    res_valid_q;

	func_t             func;
	logic              acc, ctx_ok, sym_ok, out_free;
	logic [CTX_AW-1:0] ctx_a;
	logic [SYM_AW-1:0] sym_a;

	len_row_t  len_rd;
	code_row_t code_rd;
	match_t    match;

	logic                   len_we, rd_en;
	logic                   code_we;
	code_ent_t              code_wd;
	logic [NUM_SYMBOLS-1:0] cand;
	logic                   any;
	logic [SYM_AW-1:0]      pick;
	logic                   emit, step_len, res_load, build_end;
	logic                   ovf_now;
	logic [V_W-1:0]         v_inc, v_sat;

	assign func     = func_t'(cmd.func);
	assign acc      = cmd.valid && cmd.ready;
	assign ctx_ok   = int'(cmd.context_index) < NUM_CONTEXTS;
	assign sym_ok   = int'(cmd.symbol_index) < NUM_SYMBOLS;
	assign ctx_a    = cmd.context_index[CTX_AW-1:0];
	assign sym_a    = cmd.symbol_index[SYM_AW-1:0];
	assign out_free = !res_valid_q || res.ready;

	assign cmd.ready = (state_q == ST_IDLE);

	assign len_we = acc && (func == FUNC_WRITE) && ctx_ok && sym_ok;
	assign rd_en  = acc && ((func == FUNC_BUILD) || (func == FUNC_LOOKUP)) && ctx_ok;

	cpcb_lane_ram #(
		.LANES  (NUM_SYMBOLS),
		.LANE_W (LEN_W),
		.DEPTH  (NUM_CONTEXTS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (ctx_a),
		.wlane (NUM_SYMBOLS'(1) << sym_a),
		.wdata (clamp_len(cmd.length_value)),
		.re    (rd_en),
		.raddr (ctx_a),
		.rdata (len_rd)
	);

	cpcb_lane_ram #(
		.LANES  (NUM_SYMBOLS),
		.LANE_W ($bits(code_ent_t)),
		.DEPTH  (NUM_CONTEXTS)
	) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.waddr (ctx_q),
		.wlane (NUM_SYMBOLS'(1) << pick),
		.wdata (code_wd),
		.re    (rd_en),
		.raddr (ctx_a),
		.rdata (code_rd)
	);

	cpcb_match u_match (
		.lens   (len_rd),
		.codes  (code_rd),
		.window (win_q),
		.match  (match)
	);

	// build: lowest unsent symbol at the current length
	always_comb begin
		for (int s = 0; s < NUM_SYMBOLS; s++) begin
			cand[s] = !done_q[s] && (len_rd[s] == cur_len_q);
		end
		any  = |cand;
		pick = '0;
		for (int s = NUM_SYMBOLS - 1; s >= 0; s--) begin
			if (cand[s]) begin
				pick = SYM_AW'(s);
			end
		end
	end

	assign ovf_now = (v_q >> cur_len_q) != '0;
	assign v_inc   = v_q + V_W'(1);
	assign v_sat   = (v_inc > V_W'(32'hFFFF)) ? V_W'(32'h10000) : v_inc;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (func)
						FUNC_BUILD:  state_nxt = ctx_ok ? ST_BUILD : ST_IDLE;
						FUNC_LOOKUP: state_nxt = ST_LOOK;
						FUNC_WRITE,
						FUNC_NONE:   state_nxt = ST_IDLE;
						default:     state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_LOOK: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_BUILD: begin
				if (any && out_free && (int'(cnt_q) == NUM_SYMBOLS - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		emit     = 1'b0;
		step_len = 1'b0;
		res_load = 1'b0;
		res_d    = '0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_LOOK: begin
				res_load   = out_free;
				res_d.last = 1'b1;
				if (look_ok_q && match.hit) begin
					res_d.sym   = SYM_W'(match.sym);
					res_d.code  = CODE_W'(code_rd[match.sym].code);
					res_d.len   = len_rd[match.sym];
					res_d.found = 1'b1;
				end
			end
			ST_BUILD: begin
				emit           = any && out_free;
				step_len       = !any;
				res_load       = emit;
				res_d.sym      = SYM_W'(pick);
				res_d.code     = CODE_W'(v_q[MAX_LEN-1:0]);
				res_d.len      = cur_len_q;
				res_d.overflow = ovf_now;
				res_d.last     = (int'(cnt_q) == NUM_SYMBOLS - 1);
			end
			default: begin
			end
		endcase
	end

	assign build_end    = emit && (int'(cnt_q) == NUM_SYMBOLS - 1);
	assign code_we      = emit;
	assign code_wd.ovf  = ovf_now;
	assign code_wd.code = v_q[MAX_LEN-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			built_q     <= '0;
			res_valid_q <= 1'b0;
			done_q      <= '0;
			cnt_q       <= '0;
			cur_len_q   <= '0;
			v_q         <= '0;
			look_ok_q   <= 1'b0;
			ctx_q       <= '0;
		end else begin
			state_q <= state_nxt;

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			if (len_we) begin
				built_q[ctx_a] <= 1'b0;
			end
			if (build_end) begin
				built_q[ctx_q] <= 1'b1;
			end

			if (acc) begin
				ctx_q     <= ctx_a;
				look_ok_q <= ctx_ok && built_q[ctx_a];
				done_q    <= '0;
				cnt_q     <= '0;
				cur_len_q <= LEN_W'(1);
				v_q       <= '0;
			end else if (emit) begin
				done_q[pick] <= 1'b1;
				cnt_q        <= cnt_q + SYM_AW'(1);
				v_q          <= v_sat;
			end else if (step_len) begin
				cur_len_q <= cur_len_q + LEN_W'(1);
				v_q       <= v_q << 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			win_q <= cmd.bit_window;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.out_symbol = res_q.sym;
	assign res.out_code   = res_q.code;
	assign res.out_length = res_q.len;
	assign res.found      = res_q.found;
	assign res.overflow   = res_q.overflow;
	assign res.last       = res_q.last;

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUILD) |-> ($countones(done_q) == int'(cnt_q)))
		else $error("sent-symbol mask disagrees with word count");

	a_build_end: assert property (@(posedge clk) disable iff (!arst_n)
		build_end |=> (res_valid_q && res_q.last && (state_q == ST_IDLE)))
		else $error("build did not close with a last word");

	a_look_word: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOOK) && out_free) |=>
			(res_valid_q && res_q.last && !res_q.overflow))
		else $error("lookup word malformed");

endmodule
